@@ hdl/dfl_pkg.sv @@
package dfl_pkg;

  localparam int MAX_PIXELS_DEF     = 16384;
  localparam int MAX_NODES_DEF      = 4096;
  localparam int MAX_TREES_DEF      = 16;
  localparam int MAX_WALK_DEPTH_DEF = 32;

  localparam int DEPTH_W = 17;
  localparam logic [DEPTH_W-1:0] MISSING_DEPTH = 17'd100000;

  typedef enum logic [1:0] {
    CMD_PIXEL    = 2'd0,
    CMD_NODE     = 2'd1,
    CMD_ROOT     = 2'd2,
    CMD_CLASSIFY = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TREES  = 2'd2;

  typedef struct packed {
    logic [16:0] ax;
    logic [16:0] ay;
    logic [16:0] bx;
    logic [16:0] by;
    logic signed [17:0] thr;
    logic        leaf;
    logic [11:0] left;
    logic [11:0] right;
    logic [15:0] score;
  } node_t;

  typedef struct packed {
    logic        start;
    logic [21:0] dividend;
    logic [6:0]  divisor;
  } div_req_t;

endpackage

@@ hdl/dfl_pixel_mem.sv @@
module dfl_pixel_mem #(
  parameter int DEPTH = dfl_pkg::MAX_PIXELS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  // write one pixel, read one pixel a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/dfl_node_mem.sv @@
module dfl_node_mem #(
  parameter int DEPTH = dfl_pkg::MAX_NODES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  dfl_pkg::node_t wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output dfl_pkg::node_t rdata
);

  dfl_pkg::node_t mem [DEPTH];
  dfl_pkg::node_t rdata_r;

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/dfl_mean_div.sv @@
module dfl_mean_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dfl_pkg::div_req_t req,
  output logic              done,
  output logic [15:0]       quotient
);

  localparam int SW = 22;
  localparam int CW = $clog2(SW + 1);

  logic [SW-1:0] quot_r, quot_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [6:0]    dvs_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r;
  logic [7:0]    trial;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial    = {rem_r[6:0], quot_r[SW-1]};
    quot_nxt = {quot_r[SW-2:0], 1'b0};
    rem_nxt  = trial;
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt     = trial - {1'b0, dvs_r};
      quot_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r  <= 1'b1;
        cnt_r  <= CW'(SW);
        quot_r <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (run_r) begin
        quot_r <= quot_nxt;
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quot_r[15:0];

endmodule

@@ hdl/depth_forest_leaf_lookup_unit.sv @@
// Depth forest leaf lookup. Pixel, node and root writes are taken one per
// cycle while the block is not busy and give no result. A classify command
// with a nonzero tree count raises busy and walks each tree from its root;
// every inner node takes a node read, probe scaling, address multiply, two
// reads in turn through the one read port of the pixel memory, and a compare.
// Each tree also takes a root fetch, final node read and leaf report; the
// last result waits for the serial mean divider. Results are one-cycle beats
// on out_strobe and must be taken when shown: the receiver cannot stall the
// block.
module depth_forest_leaf_lookup_unit #(
  parameter int MAX_PIXELS     = dfl_pkg::MAX_PIXELS_DEF,
  parameter int MAX_NODES      = dfl_pkg::MAX_NODES_DEF,
  parameter int MAX_TREES      = dfl_pkg::MAX_TREES_DEF,
  parameter int MAX_WALK_DEPTH = dfl_pkg::MAX_WALK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   in_cmd,
  input  logic [13:0]  in_target_address,
  input  logic [15:0]  in_depth_value,
  input  logic         in_is_leaf,
  input  logic [16:0]  in_probe_ax,
  input  logic [16:0]  in_probe_ay,
  input  logic [16:0]  in_probe_bx,
  input  logic [16:0]  in_probe_by,
  input  logic signed [17:0] in_split_threshold,
  input  logic [11:0]  in_left_child,
  input  logic [11:0]  in_right_child,
  input  logic [15:0]  in_leaf_score,
  output logic         out_strobe,
  output logic [3:0]   out_tree_index,
  output logic [11:0]  out_leaf_node,
  output logic [15:0]  out_leaf_probability,
  output logic [15:0]  out_mean_probability,
  output logic         out_last_result,
  output logic         out_depth_exceeded,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  localparam int PAW  = $clog2(MAX_PIXELS);
  localparam int NAW  = $clog2(MAX_NODES);
  localparam int TRW  = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
  localparam int TCW  = $clog2(MAX_TREES + 1);
  localparam int STW  = $clog2(MAX_WALK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_LOAD, S_NODE, S_EVAL, S_ADDR, S_RDA, S_RDB, S_CMP, S_DIV
  } state_t;

  state_t state_r;

  logic [7:0]     width_r, height_r;
  logic [4:0]     trees_r;
  logic [TCW-1:0] nt_r, tree_r;
  logic [STW-1:0] steps_r;
  logic [11:0]    node_r;
  logic [11:0]    root_q_r;
  logic [11:0]    root_mem [MAX_TREES];
  logic [21:0]    sum_r;
  logic [24:0]    pax_r, pay_r, pbx_r, pby_r;
  logic [16:0]    addr_a_r, addr_b_r;
  logic [dfl_pkg::DEPTH_W-1:0] da_r;

  logic           out_strobe_r, out_last_r, out_exc_r;
  logic [3:0]     out_tree_r;
  logic [11:0]    out_node_r;
  logic [15:0]    out_prob_r, out_mean_r;

  logic [7:0]     w_eff, h_eff, wm1, hm1;
  logic [TCW-1:0] nt_sel;
  logic           accept, node_ok;
  dfl_pkg::node_t nd, node_rd, node_wr;
  logic [15:0]    pix_rd;
  logic [PAW-1:0] pix_raddr;
  logic [dfl_pkg::DEPTH_W-1:0] depth_now;
  logic signed [17:0] diff;
  logic [7:0]     xa, ya, xb, yb;
  dfl_pkg::div_req_t div_req;
  logic           div_done;
  logic [15:0]    div_q;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign w_eff = (width_r == 8'd0) ? 8'd1 : width_r;
  assign h_eff = (height_r == 8'd0) ? 8'd1 : height_r;
  assign wm1   = w_eff - 8'd1;
  assign hm1   = h_eff - 8'd1;
  assign nt_sel = (32'(trees_r) > MAX_TREES) ? TCW'(MAX_TREES) : TCW'(trees_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd128;
      height_r <= 8'd128;
      trees_r  <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dfl_pkg::REG_WIDTH:  width_r  <= cfg_data;
        dfl_pkg::REG_HEIGHT: height_r <= cfg_data;
        dfl_pkg::REG_TREES:  trees_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // root table: write on root command, read at the current tree
  always_ff @(posedge clk) begin
    if (accept && in_cmd == dfl_pkg::CMD_ROOT && 32'(in_target_address) < MAX_TREES) begin
      root_mem[TRW'(32'(in_target_address))] <= in_left_child;
    end
    root_q_r <= root_mem[TRW'(32'(tree_r))];
  end

  // node table
  assign node_wr = '{ax: in_probe_ax, ay: in_probe_ay, bx: in_probe_bx, by: in_probe_by,
                     thr: in_split_threshold, leaf: in_is_leaf, left: in_left_child,
                     right: in_right_child, score: in_leaf_score};

  dfl_node_mem #(.DEPTH(MAX_NODES), .AW(NAW)) u_node_mem (
    .clk   (clk),
    .we    (accept && in_cmd == dfl_pkg::CMD_NODE && 32'(in_target_address) < MAX_NODES),
    .waddr (NAW'(32'(in_target_address))),
    .wdata (node_wr),
    .re    (state_r == S_NODE),
    .raddr (NAW'(32'(node_r))),
    .rdata (node_rd)
  );

  assign node_ok = (32'(node_r) < MAX_NODES);
  assign nd      = node_ok ? node_rd : '0;

  // pixel store, one read port shared by both probes
  assign pix_raddr = (state_r == S_RDA) ? PAW'(addr_a_r) : PAW'(addr_b_r);

  dfl_pixel_mem #(.DEPTH(MAX_PIXELS), .AW(PAW)) u_pixel_mem (
    .clk   (clk),
    .we    (accept && in_cmd == dfl_pkg::CMD_PIXEL && 32'(in_target_address) < MAX_PIXELS),
    .waddr (PAW'(32'(in_target_address))),
    .wdata (in_depth_value),
    .raddr (pix_raddr),
    .rdata (pix_rd)
  );

  function automatic logic [dfl_pkg::DEPTH_W-1:0] MISSING_SEL(input logic [15:0] d);
    MISSING_SEL = (d == 16'd0) ? dfl_pkg::MISSING_DEPTH : {1'b0, d};
  endfunction

  function automatic logic [7:0] sat_coord(input logic [24:0] p, input logic [7:0] lim);
    logic [8:0] c;
    c = p[24:16];
    sat_coord = (c > {1'b0, lim}) ? lim : c[7:0];
  endfunction

  // pick the address in flight for the range check of the data read back
  always_comb begin
    logic ok;
    ok = (state_r == S_RDB) ? (32'(addr_a_r) < MAX_PIXELS) : (32'(addr_b_r) < MAX_PIXELS);
    depth_now = MISSING_SEL(ok ? pix_rd : 16'd0);
  end

  assign xa = sat_coord(pax_r, wm1);
  assign ya = sat_coord(pay_r, hm1);
  assign xb = sat_coord(pbx_r, wm1);
  assign yb = sat_coord(pby_r, hm1);

  assign diff = $signed({1'b0, da_r}) - $signed({1'b0, depth_now});

  // mean divider
  always_comb begin
    div_req          = '0;
    div_req.dividend = sum_r;
    div_req.divisor  = 7'(nt_r);
    div_req.start    = 1'b0;
    if (state_r == S_EVAL && 32'(tree_r) + 1 == 32'(nt_r)) begin
      div_req.start = nd.leaf || 32'(steps_r) >= MAX_WALK_DEPTH;
      div_req.dividend = sum_r + (nd.leaf ? 22'(nd.score) : 22'd0);
    end
  end

  dfl_mean_div u_mean_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // walk sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      steps_r      <= '0;
      tree_r       <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_cmd == dfl_pkg::CMD_CLASSIFY && nt_sel != '0) begin
            nt_r    <= nt_sel;
            tree_r  <= '0;
            sum_r   <= '0;
            state_r <= S_ROOT;
          end
        end
        S_ROOT: state_r <= S_LOAD;
        S_LOAD: begin
          node_r  <= root_q_r;
          steps_r <= '0;
          state_r <= S_NODE;
        end
        S_NODE: state_r <= S_EVAL;
        S_EVAL: begin
          if (nd.leaf || 32'(steps_r) >= MAX_WALK_DEPTH) begin
            out_tree_r <= 4'(tree_r);
            out_node_r <= node_r;
            out_prob_r <= nd.leaf ? nd.score : 16'd0;
            out_exc_r  <= !nd.leaf;
            out_mean_r <= '0;
            if (32'(tree_r) + 1 == 32'(nt_r)) begin
              out_last_r <= 1'b1;
              state_r    <= S_DIV;
            end else begin
              out_last_r   <= 1'b0;
              out_strobe_r <= 1'b1;
              sum_r        <= sum_r + (nd.leaf ? 22'(nd.score) : 22'd0);
              tree_r       <= tree_r + 1'b1;
              state_r      <= S_ROOT;
            end
          end else begin
            pax_r   <= nd.ax * wm1;
            pay_r   <= nd.ay * hm1;
            pbx_r   <= nd.bx * wm1;
            pby_r   <= nd.by * hm1;
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          addr_a_r <= 17'(ya) * 17'(w_eff) + 17'(xa);
          addr_b_r <= 17'(yb) * 17'(w_eff) + 17'(xb);
          state_r  <= S_RDA;
        end
        S_RDA: state_r <= S_RDB;
        S_RDB: begin
          da_r    <= depth_now;
          state_r <= S_CMP;
        end
        S_CMP: begin
          node_r  <= (diff <= nd.thr) ? nd.left : nd.right;
          steps_r <= steps_r + 1'b1;
          state_r <= S_NODE;
        end
        S_DIV: begin
          if (div_done) begin
            out_mean_r   <= div_q;
            out_strobe_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe           = out_strobe_r;
  assign out_tree_index       = out_tree_r;
  assign out_leaf_node        = out_node_r;
  assign out_leaf_probability = out_prob_r;
  assign out_mean_probability = out_mean_r;
  assign out_last_result      = out_last_r;
  assign out_depth_exceeded   = out_exc_r;

  a_exc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_depth_exceeded |-> out_leaf_probability == 16'd0)
    else $error("exceeded walk reports a nonzero score");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(steps_r) <= MAX_WALK_DEPTH)
    else $error("walk step count past the depth bound");

  a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_cmd == dfl_pkg::CMD_CLASSIFY && nt_sel != '0 |=> busy)
    else $error("classify did not raise busy");

  a_mean_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_result |-> out_mean_probability == 16'd0)
    else $error("mean shown on a result that is not last");

endmodule
